@@ src/svpwm_ctc_pkg.sv @@
// shared types and constants for the svpwm compare time unit
// no dependencies; used by svpwm_ctc_mul, svpwm_ctc_div and svpwm_compare_times_unit
package svpwm_ctc_pkg;

   // payload of one input transfer
   typedef struct packed {
      logic signed [15:0] v_alpha;
      logic signed [15:0] v_beta;
      logic [14:0]        v_bus;
   } req_payload_type;

   // payload of one result transfer
   typedef struct packed {
      logic [14:0] compare_a;
      logic [14:0] compare_b;
      logic [14:0] compare_c;
      logic [2:0]  sector_code;
      logic        overmodulated;
   } rsp_payload_type;

   // fixed point constants, 14 fraction bits (Q1.14 and Q0.14)
   localparam logic [14:0] SQRT3_Q14      = 15'd28378;
   localparam logic [13:0] SQRT3_HALF_Q14 = 14'd14189;

   localparam logic [15:0] PERIOD_RESET = 16'd4096;

   // sector codes, bit0 beta > 0, bit1 vref2 > 0, bit2 vref3 > 0
   localparam logic [2:0] SECT_NONE = 3'd0;
   localparam logic [2:0] SECT_A    = 3'd1;
   localparam logic [2:0] SECT_B    = 3'd2;
   localparam logic [2:0] SECT_AB   = 3'd3;
   localparam logic [2:0] SECT_C    = 3'd4;
   localparam logic [2:0] SECT_AC   = 3'd5;
   localparam logic [2:0] SECT_BC   = 3'd6;
   localparam logic [2:0] SECT_ABC  = 3'd7;

   // datapath widths
   localparam int KA_W   = 29;  // 14189 * |alpha|
   localparam int GAIN_W = 31;  // 28378 * period
   localparam int MAG_W  = 30;  // projection magnitude in q14
   localparam int TIME_W = 33;  // active time before scaling
   localparam int SUM_W  = 34;  // t1 + t2

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 31;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int DIVIDEND_W  = 49;
   localparam int DIVISOR_W   = SUM_W;
   localparam int SHORT_STEPS = TIME_W;
   localparam int CNT_W       = $clog2(DIVIDEND_W + 1);

   typedef struct packed {
      logic start;
      logic short_op;  // dividend sits in the low SHORT_STEPS bits
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ src/svpwm_compare_times_unit.sv @@
// channel   | ports                              | transfer when
// ----------+------------------------------------+-------------------------
// request   | req_valid, req_stall, req_payload  | req_valid & !req_stall
// response  | rsp_valid, rsp_stall, rsp_payload  | rsp_valid & !rsp_stall
// csr       | csr_write_enable, csr_write_data   | csr_write_enable
//
// seven-segment svpwm compare generator, top level
// depends on svpwm_ctc_pkg, svpwm_ctc_mul and svpwm_ctc_div
// one item at a time: a new request is accepted only once the result has been taken
// the arithmetic runs on the one-bit-per-cycle divider: two 33-step divides by the bus
// voltage, plus two 49-step divides by t1+t2 when overmodulated
// sector codes zero and seven skip the remaining arithmetic and go straight to the result
// synchronous reset: period 4096, held compares zero, no result pending
// req_stall stays high from the accepted transfer until the result is taken
module svpwm_compare_times_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  svpwm_ctc_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output svpwm_ctc_pkg::rsp_payload_type rsp_payload,
   input  logic                           csr_write_enable,
   input  logic [15:0]                    csr_write_data
);

   localparam int KA_W   = svpwm_ctc_pkg::KA_W;
   localparam int GAIN_W = svpwm_ctc_pkg::GAIN_W;
   localparam int MAG_W  = svpwm_ctc_pkg::MAG_W;
   localparam int TIME_W = svpwm_ctc_pkg::TIME_W;
   localparam int SUM_W  = svpwm_ctc_pkg::SUM_W;
   localparam int MA_W   = svpwm_ctc_pkg::MUL_A_W;
   localparam int MB_W   = svpwm_ctc_pkg::MUL_B_W;
   localparam int P_W    = svpwm_ctc_pkg::PROD_W;
   localparam int NW     = svpwm_ctc_pkg::DIVIDEND_W;
   localparam int DW     = svpwm_ctc_pkg::DIVISOR_W;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_MK   = 5'd1;
   localparam logic [4:0] ST_MG   = 5'd2;
   localparam logic [4:0] ST_PROJ = 5'd3;
   localparam logic [4:0] ST_M1   = 5'd4;
   localparam logic [4:0] ST_D1S  = 5'd5;
   localparam logic [4:0] ST_D1W  = 5'd6;
   localparam logic [4:0] ST_M2   = 5'd7;
   localparam logic [4:0] ST_D2S  = 5'd8;
   localparam logic [4:0] ST_D2W  = 5'd9;
   localparam logic [4:0] ST_SUM  = 5'd10;
   localparam logic [4:0] ST_M3   = 5'd11;
   localparam logic [4:0] ST_D3S  = 5'd12;
   localparam logic [4:0] ST_D3W  = 5'd13;
   localparam logic [4:0] ST_M4   = 5'd14;
   localparam logic [4:0] ST_D4S  = 5'd15;
   localparam logic [4:0] ST_D4W  = 5'd16;
   localparam logic [4:0] ST_CMP  = 5'd17;
   localparam logic [4:0] ST_OUT  = 5'd18;

   logic [4:0]                     state_ff, state_in;
   logic [15:0]                    period_ff, period_in;
   svpwm_ctc_pkg::req_payload_type item_ff, item_in;
   logic [14:0]                    bus_ff, bus_in;
   logic [KA_W-1:0]                ka_ff, ka_in;
   logic [GAIN_W-1:0]              gain_ff, gain_in;
   logic [MAG_W-1:0]               m1_ff, m1_in;
   logic [MAG_W-1:0]               m2_ff, m2_in;
   logic [2:0]                     sect_ff, sect_in;
   logic                           ovm_ff, ovm_in;
   logic [TIME_W-1:0]              t1_ff, t1_in;
   logic [TIME_W-1:0]              t2_ff, t2_in;
   logic [SUM_W-1:0]               s_ff, s_in;
   logic [14:0]                    held_a_ff, held_a_in;
   logic [14:0]                    held_b_ff, held_b_in;
   logic [14:0]                    held_c_ff, held_c_in;

   // shared arithmetic
   logic [MA_W-1:0]              mul_a;
   logic [MB_W-1:0]              mul_b;
   logic [P_W-1:0]               product;
   svpwm_ctc_pkg::div_ctrl_type  div_ctrl;
   svpwm_ctc_pkg::div_stat_type  div_stat;
   logic [NW-1:0]                dividend;
   logic [DW-1:0]                divisor;
   logic [NW-1:0]                quotient;

   // projection datapath
   logic signed [16:0] al_ext, be_ext17;
   logic [15:0]        al_mag, be_mag;
   logic signed [31:0] at, bt, p2, p3;
   logic [MAG_W-1:0]   p2_mag, p3_mag, be_q14;
   logic [2:0]         sect_new;
   logic [SUM_W-1:0]   t_sum;

   // compare datapath
   logic [17:0] ts18, t1_18, t2_18, ta_full, tb_full, tc_full;
   logic [14:0] ta, tb, tc;

   logic req_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_take  = req_valid && !req_stall;

   svpwm_ctc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   svpwm_ctc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .dividend (dividend),
      .divisor  (divisor),
      .div_stat (div_stat),
      .quotient (quotient)
   );

   // sign handling and sector detection
   always_comb begin
      al_ext   = 17'(item_ff.v_alpha);
      be_ext17 = 17'(item_ff.v_beta);
      al_mag   = al_ext[16] ? 16'(-al_ext) : al_ext[15:0];
      be_mag   = be_ext17[16] ? 16'(-be_ext17) : be_ext17[15:0];
      at       = al_ext[16] ? -$signed({3'b000, ka_ff}) : $signed({3'b000, ka_ff});
      bt       = 32'(item_ff.v_beta) <<< 13;
      p2       = at - bt;
      p3       = -at - bt;
      p2_mag   = p2[31] ? MAG_W'(-p2) : p2[MAG_W-1:0];
      p3_mag   = p3[31] ? MAG_W'(-p3) : p3[MAG_W-1:0];
      be_q14   = {be_mag, 14'b0};
      sect_new = {p3 > 0, p2 > 0, item_ff.v_beta > 0};
      t_sum    = SUM_W'(t1_ff) + SUM_W'(t2_ff);
   end

   // quarter-period compares; both times are at most the period here
   always_comb begin
      ts18    = 18'(period_ff);
      t1_18   = 18'(t1_ff[15:0]);
      t2_18   = 18'(t2_ff[15:0]);
      ta_full = ts18 - t1_18 - t2_18;
      tb_full = ts18 + t1_18 - t2_18;
      tc_full = ts18 + t1_18 + t2_18;
      ta      = ta_full[16:2];
      tb      = tb_full[16:2];
      tc      = tc_full[16:2];
   end

   // operand routing for the shared units
   always_comb begin
      mul_a             = '0;
      mul_b             = '0;
      div_ctrl.start    = 1'b0;
      div_ctrl.short_op = 1'b0;
      dividend          = NW'(product[P_W-1:28]);
      divisor           = DW'(bus_ff);
      case (state_ff)
         ST_MK: begin
            mul_a = MA_W'(al_mag);
            mul_b = MB_W'(svpwm_ctc_pkg::SQRT3_HALF_Q14);
         end
         ST_MG: begin
            mul_a = MA_W'(period_ff);
            mul_b = MB_W'(svpwm_ctc_pkg::SQRT3_Q14);
         end
         ST_M1: begin
            mul_a = MA_W'(m1_ff);
            mul_b = gain_ff;
         end
         ST_M2: begin
            mul_a = MA_W'(m2_ff);
            mul_b = gain_ff;
         end
         ST_M3: begin
            mul_a = t1_ff;
            mul_b = MB_W'(period_ff);
         end
         ST_M4: begin
            mul_a = t2_ff;
            mul_b = MB_W'(period_ff);
         end
         ST_D1S, ST_D2S: begin
            // gain * projection / (bus << 28): drop the 28 bits first
            div_ctrl.start    = 1'b1;
            div_ctrl.short_op = 1'b1;
            dividend          = NW'(product[TIME_W+27:28]);
            divisor           = DW'(bus_ff);
         end
         ST_D3S, ST_D4S: begin
            div_ctrl.start = 1'b1;
            dividend       = product[NW-1:0];
            divisor        = s_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      period_in = period_ff;
      item_in   = item_ff;
      bus_in    = bus_ff;
      ka_in     = ka_ff;
      gain_in   = gain_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      sect_in   = sect_ff;
      ovm_in    = ovm_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      s_in      = s_ff;
      held_a_in = held_a_ff;
      held_b_in = held_b_ff;
      held_c_in = held_c_ff;
      if (csr_write_enable) begin
         period_in = csr_write_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in  = req_payload;
               bus_in   = (req_payload.v_bus == '0) ? 15'd1 : req_payload.v_bus;
               state_in = ST_MK;
            end
         end
         ST_MK: begin
            state_in = ST_MG;
         end
         ST_MG: begin
            ka_in    = product[KA_W-1:0];
            state_in = ST_PROJ;
         end
         ST_PROJ: begin
            gain_in = product[GAIN_W-1:0];
            sect_in = sect_new;
            ovm_in  = 1'b0;
            m1_in   = p3_mag;
            m2_in   = be_q14;
            case (sect_new)
               svpwm_ctc_pkg::SECT_AB: begin
                  m1_in = p2_mag;
                  m2_in = be_q14;
               end
               svpwm_ctc_pkg::SECT_A: begin
                  m1_in = p2_mag;
                  m2_in = p3_mag;
               end
               svpwm_ctc_pkg::SECT_AC: begin
                  m1_in = be_q14;
                  m2_in = p3_mag;
               end
               svpwm_ctc_pkg::SECT_C: begin
                  m1_in = be_q14;
                  m2_in = p2_mag;
               end
               svpwm_ctc_pkg::SECT_BC: begin
                  m1_in = p3_mag;
                  m2_in = p2_mag;
               end
               default: begin
                  m1_in = p3_mag;
                  m2_in = be_q14;
               end
            endcase
            if (sect_new == svpwm_ctc_pkg::SECT_NONE || sect_new == svpwm_ctc_pkg::SECT_ABC) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_M1;
            end
         end
         ST_M1:  state_in = ST_D1S;
         ST_D1S: state_in = ST_D1W;
         ST_D1W: begin
            if (div_stat.done) begin
               t1_in    = quotient[TIME_W-1:0];
               state_in = ST_M2;
            end
         end
         ST_M2:  state_in = ST_D2S;
         ST_D2S: state_in = ST_D2W;
         ST_D2W: begin
            if (div_stat.done) begin
               t2_in    = quotient[TIME_W-1:0];
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            s_in = t_sum;
            if (t_sum > SUM_W'(period_ff)) begin
               ovm_in   = 1'b1;
               state_in = ST_M3;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_M3:  state_in = ST_D3S;
         ST_D3S: state_in = ST_D3W;
         ST_D3W: begin
            if (div_stat.done) begin
               t1_in    = quotient[TIME_W-1:0];
               state_in = ST_M4;
            end
         end
         ST_M4:  state_in = ST_D4S;
         ST_D4S: state_in = ST_D4W;
         ST_D4W: begin
            if (div_stat.done) begin
               t2_in    = quotient[TIME_W-1:0];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // route the three compares to the phases by sector
            case (sect_ff)
               svpwm_ctc_pkg::SECT_AB: begin
                  held_a_in = ta;
                  held_b_in = tb;
                  held_c_in = tc;
               end
               svpwm_ctc_pkg::SECT_A: begin
                  held_a_in = tb;
                  held_b_in = ta;
                  held_c_in = tc;
               end
               svpwm_ctc_pkg::SECT_AC: begin
                  held_a_in = tc;
                  held_b_in = ta;
                  held_c_in = tb;
               end
               svpwm_ctc_pkg::SECT_C: begin
                  held_a_in = tc;
                  held_b_in = tb;
                  held_c_in = ta;
               end
               svpwm_ctc_pkg::SECT_BC: begin
                  held_a_in = tb;
                  held_b_in = tc;
                  held_c_in = ta;
               end
               default: begin
                  held_a_in = ta;
                  held_b_in = tc;
                  held_c_in = tb;
               end
            endcase
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         period_ff <= svpwm_ctc_pkg::PERIOD_RESET;
         held_a_ff <= '0;
         held_b_ff <= '0;
         held_c_ff <= '0;
         ovm_ff    <= 1'b0;
         sect_ff   <= svpwm_ctc_pkg::SECT_NONE;
      end else begin
         state_ff  <= state_in;
         period_ff <= period_in;
         held_a_ff <= held_a_in;
         held_b_ff <= held_b_in;
         held_c_ff <= held_c_in;
         ovm_ff    <= ovm_in;
         sect_ff   <= sect_in;
      end
      item_ff <= item_in;
      bus_ff  <= bus_in;
      ka_ff   <= ka_in;
      gain_ff <= gain_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      s_ff    <= s_in;
   end

   always_comb begin
      rsp_payload.compare_a     = held_a_ff;
      rsp_payload.compare_b     = held_b_ff;
      rsp_payload.compare_c     = held_c_ff;
      rsp_payload.sector_code   = sect_ff;
      rsp_payload.overmodulated = ovm_ff;
   end

`ifndef SYNTHESIS
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   a_ovm_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overmodulated |->
         (rsp_payload.sector_code != svpwm_ctc_pkg::SECT_NONE) &&
         (rsp_payload.sector_code != svpwm_ctc_pkg::SECT_ABC))
      else $error("overmodulation flagged on a held sector");

   a_result_retires: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after the result transfer");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_D1W || state_ff == ST_D2W ||
                         state_ff == ST_D3W || state_ff == ST_D4W))
      else $error("divider finished outside a wait state");
`endif

endmodule

@@ src/svpwm_ctc_mul.sv @@
// shared unsigned multiplier with a registered product
// depends on svpwm_ctc_pkg for operand widths
module svpwm_ctc_mul (
   input  logic                                clock,
   input  logic [svpwm_ctc_pkg::MUL_A_W-1:0]   mul_a,
   input  logic [svpwm_ctc_pkg::MUL_B_W-1:0]   mul_b,
   output logic [svpwm_ctc_pkg::PROD_W-1:0]    product
);

   logic [svpwm_ctc_pkg::PROD_W-1:0] product_ff;
   logic [svpwm_ctc_pkg::PROD_W-1:0] product_in;

   assign product_in = svpwm_ctc_pkg::PROD_W'(mul_a) * svpwm_ctc_pkg::PROD_W'(mul_b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ src/svpwm_ctc_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on svpwm_ctc_pkg for widths and control structs
module svpwm_ctc_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  svpwm_ctc_pkg::div_ctrl_type            div_ctrl,
   input  logic [svpwm_ctc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [svpwm_ctc_pkg::DIVISOR_W-1:0]    divisor,
   output svpwm_ctc_pkg::div_stat_type            div_stat,
   output logic [svpwm_ctc_pkg::DIVIDEND_W-1:0]   quotient
);

   localparam int NW = svpwm_ctc_pkg::DIVIDEND_W;
   localparam int DW = svpwm_ctc_pkg::DIVISOR_W;
   localparam int CW = svpwm_ctc_pkg::CNT_W;

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;

   logic [DW:0] trial;
   logic [DW:0] diff;
   logic        fits;

   assign trial = {rem_ff, num_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (div_ctrl.start) begin
         den_in  = divisor;
         rem_in  = '0;
         busy_in = 1'b1;
         if (div_ctrl.short_op) begin
            // left-align the short dividend so the quotient lands in the low bits
            num_in = dividend << (NW - svpwm_ctc_pkg::SHORT_STEPS);
            cnt_in = CW'(svpwm_ctc_pkg::SHORT_STEPS);
         end else begin
            num_in = dividend;
            cnt_in = CW'(NW);
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
            num_in = {num_ff[NW-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = busy_ff && (cnt_ff == '0);
   assign quotient      = num_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !busy_ff)
      else $error("divider started while busy");

   a_steps_run: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (cnt_ff != '0) && !div_ctrl.start |=> busy_ff)
      else $error("divider stopped before its last step");
`endif

endmodule
